>>> src/wrvfm_pkg.sv
// ----------------------------------------------------------------------------
// wrvfm_pkg
// Types, constants and helpers for the wireless receiver voltage fault monitor.
// ----------------------------------------------------------------------------
package wrvfm_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int CNT_W1      = COUNT_WIDTH + 1;
  localparam int TICK_W      = 8;
  localparam int LIM_W       = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int PROD_W  = 24;

  localparam logic [2:0] REG_VOUT_RATIO     = 3'd0;
  localparam logic [2:0] REG_IGNORE_CURRENT = 3'd1;
  localparam logic [2:0] REG_VOUT_TICKS     = 3'd2;
  localparam logic [2:0] REG_DIFF_TICKS     = 3'd3;
  localparam logic [2:0] REG_DIFF_LIMIT     = 3'd4;
  localparam logic [2:0] REG_HIGH_VFC       = 3'd5;

  localparam logic [6:0]  RST_VOUT_RATIO     = 7'd81;
  localparam logic [12:0] RST_IGNORE_CURRENT = 13'd500;
  localparam logic [7:0]  RST_VOUT_TICKS     = 8'd10;
  localparam logic [7:0]  RST_DIFF_TICKS     = 8'd100;
  localparam logic [15:0] RST_DIFF_LIMIT     = 16'd2500;
  localparam logic [15:0] RST_HIGH_VFC       = 16'd12000;

  localparam logic [PROD_W-1:0] PCT_SCALE = 24'd100;

  typedef enum logic [1:0] {
    STATUS_NORMAL   = 2'd0,
    STATUS_IGNORE   = 2'd1,
    STATUS_ABNORMAL = 2'd2
  } status_t;

  typedef struct packed {
    logic [6:0]  vout_ratio_pct;
    logic [12:0] ignore_current_ma;
    logic [7:0]  vout_fault_ticks;
    logic [7:0]  diff_fault_ticks;
    logic [15:0] diff_limit_mv;
    logic [15:0] high_vfc_mv;
  } cfg_t;

  typedef struct packed {
    logic [15:0] out_volt_mv;
    logic [15:0] bus_volt_mv;
    logic [15:0] out_target_mv;
    logic [12:0] avg_current_ma;
    logic [15:0] main_rect_mv;
    logic [15:0] main_out_mv;
    logic        past_handshake;
    logic        boost_done;
    logic [15:0] vfc_target_mv;
    logic        sleep_enabled;
    logic        channel_on;
  } in_item_t;

  typedef struct packed {
    status_t status;
    logic    diff_excess;
    logic    want_limit;
    logic    channel_on;
  } class_t;

  typedef struct packed {
    status_t volt_status;
    logic    limit_power;
    logic    send_ept;
    logic    diff_fault;
  } out_item_t;

  function automatic logic [COUNT_WIDTH-1:0] clamp_limit(input logic [TICK_W-1:0] ticks);
    logic [LIM_W-1:0] t;
    t = LIM_W'(ticks);
    if (t > LIM_W'(CNT_MAX)) begin
      t = LIM_W'(CNT_MAX);
    end
    return COUNT_WIDTH'(t);
  endfunction

endpackage

>>> src/wrvfm_if.sv
// ----------------------------------------------------------------------------
// wrvfm_if
// Valid/ready channels for monitor ticks and tick results.
// ----------------------------------------------------------------------------
interface wrvfm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_volt_mv;
  logic [15:0] bus_volt_mv;
  logic [15:0] out_target_mv;
  logic [12:0] avg_current_ma;
  logic [15:0] main_rect_mv;
  logic [15:0] main_out_mv;
  logic        past_handshake;
  logic        boost_done;
  logic [15:0] vfc_target_mv;
  logic        sleep_enabled;
  logic        channel_on;

  modport source (
    output valid, out_volt_mv, bus_volt_mv, out_target_mv, avg_current_ma,
           main_rect_mv, main_out_mv, past_handshake, boost_done,
           vfc_target_mv, sleep_enabled, channel_on,
    input  ready
  );
  modport sink (
    input  valid, out_volt_mv, bus_volt_mv, out_target_mv, avg_current_ma,
           main_rect_mv, main_out_mv, past_handshake, boost_done,
           vfc_target_mv, sleep_enabled, channel_on,
    output ready
  );
endinterface

interface wrvfm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] volt_status;
  logic       limit_power;
  logic       send_ept;
  logic       diff_fault;

  modport source (
    output valid, volt_status, limit_power, send_ept, diff_fault,
    input  ready
  );
  modport sink (
    input  valid, volt_status, limit_power, send_ept, diff_fault,
    output ready
  );
endinterface

>>> src/wrvfm_regs.sv
// ----------------------------------------------------------------------------
// wrvfm_regs
// APB configuration register file for the fault monitor thresholds.
// ----------------------------------------------------------------------------
module wrvfm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrvfm_pkg::PADDR_W-1:0] paddr,
  input  logic [wrvfm_pkg::PDATA_W-1:0] pwdata,
  output logic [wrvfm_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output wrvfm_pkg::cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vout_ratio_pct    <= wrvfm_pkg::RST_VOUT_RATIO;
      cfg.ignore_current_ma <= wrvfm_pkg::RST_IGNORE_CURRENT;
      cfg.vout_fault_ticks  <= wrvfm_pkg::RST_VOUT_TICKS;
      cfg.diff_fault_ticks  <= wrvfm_pkg::RST_DIFF_TICKS;
      cfg.diff_limit_mv     <= wrvfm_pkg::RST_DIFF_LIMIT;
      cfg.high_vfc_mv       <= wrvfm_pkg::RST_HIGH_VFC;
    end else if (wr_en) begin
      unique case (idx)
        wrvfm_pkg::REG_VOUT_RATIO:     cfg.vout_ratio_pct    <= pwdata[6:0];
        wrvfm_pkg::REG_IGNORE_CURRENT: cfg.ignore_current_ma <= pwdata[12:0];
        wrvfm_pkg::REG_VOUT_TICKS:     cfg.vout_fault_ticks  <= pwdata[7:0];
        wrvfm_pkg::REG_DIFF_TICKS:     cfg.diff_fault_ticks  <= pwdata[7:0];
        wrvfm_pkg::REG_DIFF_LIMIT:     cfg.diff_limit_mv     <= pwdata[15:0];
        wrvfm_pkg::REG_HIGH_VFC:       cfg.high_vfc_mv       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wrvfm_pkg::REG_VOUT_RATIO:     prdata = 32'(cfg.vout_ratio_pct);
      wrvfm_pkg::REG_IGNORE_CURRENT: prdata = 32'(cfg.ignore_current_ma);
      wrvfm_pkg::REG_VOUT_TICKS:     prdata = 32'(cfg.vout_fault_ticks);
      wrvfm_pkg::REG_DIFF_TICKS:     prdata = 32'(cfg.diff_fault_ticks);
      wrvfm_pkg::REG_DIFF_LIMIT:     prdata = 32'(cfg.diff_limit_mv);
      wrvfm_pkg::REG_HIGH_VFC:       prdata = 32'(cfg.high_vfc_mv);
      default:                       prdata = '0;
    endcase
  end

endmodule

>>> src/wrvfm_classify.sv
// ----------------------------------------------------------------------------
// wrvfm_classify
// Per-tick voltage classification and rectifier difference check.
// ----------------------------------------------------------------------------
module wrvfm_classify (
  input  wrvfm_pkg::in_item_t item,
  input  wrvfm_pkg::cfg_t     cfg,
  output wrvfm_pkg::class_t   cls
);

  logic [15:0]                    vmax;
  logic [16:0]                    vmax_p1;
  logic [wrvfm_pkg::PROD_W-1:0]   prod;
  logic [wrvfm_pkg::PROD_W-1:0]   vmax_scaled;
  logic [16:0]                    diff_rhs;
  logic                           skip;

  // floor(p / 100) <= vmax  <=>  p < 100 * (vmax + 1)
  assign vmax        = (item.out_volt_mv >= item.bus_volt_mv) ? item.out_volt_mv
                                                              : item.bus_volt_mv;
  assign vmax_p1     = 17'(vmax) + 17'd1;
  assign prod        = wrvfm_pkg::PROD_W'(item.out_target_mv) *
                       wrvfm_pkg::PROD_W'(cfg.vout_ratio_pct);
  assign vmax_scaled = wrvfm_pkg::PROD_W'(vmax_p1) * wrvfm_pkg::PCT_SCALE;
  assign skip        = (item.out_volt_mv == 16'd0) || !item.boost_done ||
                       !item.past_handshake;

  always_comb begin
    if (skip) begin
      cls.status = wrvfm_pkg::STATUS_IGNORE;
    end else if (prod < vmax_scaled) begin
      cls.status = wrvfm_pkg::STATUS_NORMAL;
    end else if (item.avg_current_ma >= cfg.ignore_current_ma) begin
      cls.status = wrvfm_pkg::STATUS_IGNORE;
    end else begin
      cls.status = wrvfm_pkg::STATUS_ABNORMAL;
    end
  end

  assign diff_rhs        = 17'(item.main_out_mv) + 17'(cfg.diff_limit_mv);
  assign cls.diff_excess = 17'(item.main_rect_mv) >= diff_rhs;
  assign cls.want_limit  = !item.sleep_enabled && (item.vfc_target_mv >= cfg.high_vfc_mv);
  assign cls.channel_on  = item.channel_on;

endmodule

>>> src/wrvfm_pipe.sv
// ----------------------------------------------------------------------------
// wrvfm_pipe
// Input register, fault counters and result register.
// ----------------------------------------------------------------------------
module wrvfm_pipe (
  input  logic            clk,
  input  logic            rst,
  input  wrvfm_pkg::cfg_t cfg,
  wrvfm_in_if.sink        in_ch,
  wrvfm_out_if.source     out_ch
);

  logic                              s1_valid;
  wrvfm_pkg::in_item_t               s1_item;
  logic                              s2_valid;
  wrvfm_pkg::out_item_t              s2_item;
  logic [wrvfm_pkg::COUNT_WIDTH-1:0] low_vout_count;
  logic [wrvfm_pkg::COUNT_WIDTH-1:0] low_vout_count_next;
  logic [wrvfm_pkg::COUNT_WIDTH-1:0] diff_count;
  logic [wrvfm_pkg::COUNT_WIDTH-1:0] diff_count_next;
  wrvfm_pkg::out_item_t              res;
  wrvfm_pkg::class_t                 cls;
  wrvfm_pkg::in_item_t               in_item;
  logic [wrvfm_pkg::COUNT_WIDTH-1:0] lv_lim;
  logic [wrvfm_pkg::COUNT_WIDTH-1:0] df_lim;
  logic [wrvfm_pkg::CNT_W1-1:0]      lv_inc;
  logic [wrvfm_pkg::CNT_W1-1:0]      df_inc;
  logic                              s2_take;
  logic                              s1_adv;
  logic                              in_ready;

  assign in_item.out_volt_mv    = in_ch.out_volt_mv;
  assign in_item.bus_volt_mv    = in_ch.bus_volt_mv;
  assign in_item.out_target_mv  = in_ch.out_target_mv;
  assign in_item.avg_current_ma = in_ch.avg_current_ma;
  assign in_item.main_rect_mv   = in_ch.main_rect_mv;
  assign in_item.main_out_mv    = in_ch.main_out_mv;
  assign in_item.past_handshake = in_ch.past_handshake;
  assign in_item.boost_done     = in_ch.boost_done;
  assign in_item.vfc_target_mv  = in_ch.vfc_target_mv;
  assign in_item.sleep_enabled  = in_ch.sleep_enabled;
  assign in_item.channel_on     = in_ch.channel_on;

  assign s2_take     = !s2_valid || out_ch.ready;
  assign s1_adv      = s1_valid && s2_take;
  assign in_ready    = !s1_valid || s2_take;
  assign in_ch.ready = in_ready;

  wrvfm_classify u_classify (
    .item (s1_item),
    .cfg  (cfg),
    .cls  (cls)
  );

  assign lv_lim = wrvfm_pkg::clamp_limit(cfg.vout_fault_ticks);
  assign df_lim = wrvfm_pkg::clamp_limit(cfg.diff_fault_ticks);
  assign lv_inc = wrvfm_pkg::CNT_W1'(low_vout_count) + wrvfm_pkg::CNT_W1'(1);
  assign df_inc = wrvfm_pkg::CNT_W1'(diff_count) + wrvfm_pkg::CNT_W1'(1);

  always_comb begin
    res.volt_status     = cls.status;
    res.limit_power     = 1'b0;
    res.send_ept        = 1'b0;
    res.diff_fault      = 1'b0;
    low_vout_count_next = low_vout_count;
    diff_count_next     = diff_count;

    case (cls.status)
      wrvfm_pkg::STATUS_NORMAL: begin
        low_vout_count_next = '0;
      end
      wrvfm_pkg::STATUS_ABNORMAL: begin
        if (lv_inc < wrvfm_pkg::CNT_W1'(lv_lim)) begin
          low_vout_count_next = lv_inc[wrvfm_pkg::COUNT_WIDTH-1:0];
        end else begin
          low_vout_count_next = lv_lim;
          if (cls.want_limit) begin
            res.limit_power = 1'b1;
          end else if (cls.channel_on) begin
            res.send_ept = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (!cls.diff_excess) begin
      diff_count_next = '0;
    end else if (df_inc < wrvfm_pkg::CNT_W1'(df_lim)) begin
      diff_count_next = df_inc[wrvfm_pkg::COUNT_WIDTH-1:0];
    end else begin
      diff_count_next = '0;
      res.diff_fault  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      low_vout_count <= '0;
      diff_count     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_ch.valid;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
      if (s1_adv) begin
        low_vout_count <= low_vout_count_next;
        diff_count     <= diff_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_item <= in_item;
    end
    if (s1_adv) begin
      s2_item <= res;
    end
  end

  assign out_ch.valid       = s2_valid;
  assign out_ch.volt_status = s2_item.volt_status;
  assign out_ch.limit_power = s2_item.limit_power;
  assign out_ch.send_ept    = s2_item.send_ept;
  assign out_ch.diff_fault  = s2_item.diff_fault;

endmodule

>>> src/wireless_rx_voltage_fault_monitor_top.sv
// ----------------------------------------------------------------------------
// wireless_rx_voltage_fault_monitor_top
// Output voltage and rectifier difference fault monitor, one tick per transaction.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  in_ch    | in  | valid/ready    | voltages, current, status flags of one tick
//  out_ch   | out | valid/ready    | volt_status, limit_power, send_ept, diff_fault
//  apb      | in  | psel/penable   | six threshold registers at 4*i, pready tied high
//
//  One tick per cycle sustained while out_ch.ready stays high; each tick passes the
//  input register, then the result register through the classify/counter logic.
//  Synchronous reset clears both counters, empties both stages, and loads
//  register defaults. A stalled result holds in the result register while the
//  input register still takes one more tick; in_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
module wireless_rx_voltage_fault_monitor_top (
  input  logic                          clk,
  input  logic                          rst,
  wrvfm_in_if.sink                      in_ch,
  wrvfm_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrvfm_pkg::PADDR_W-1:0] paddr,
  input  logic [wrvfm_pkg::PDATA_W-1:0] pwdata,
  output logic [wrvfm_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  wrvfm_pkg::cfg_t cfg;

  wrvfm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wrvfm_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

>>> src/wrvfm_checker.sv
// ----------------------------------------------------------------------------
// wrvfm_checker
// Port-level assertions for the voltage fault monitor.
// ----------------------------------------------------------------------------
module wrvfm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] volt_status,
  input logic       limit_power,
  input logic       send_ept
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(limit_power && send_ept))
    else $error("power limit and ept requested together");

  a_action_abnormal: assert property (@(posedge clk) disable iff (rst)
    out_valid && (limit_power || send_ept) |->
      volt_status == wrvfm_pkg::STATUS_ABNORMAL)
    else $error("voltage action on a non-abnormal tick");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind wireless_rx_voltage_fault_monitor_top wrvfm_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .volt_status (out_ch.volt_status),
  .limit_power (out_ch.limit_power),
  .send_ept    (out_ch.send_ept)
);

>>> tb/sv/wireless_rx_voltage_fault_monitor_top_test.sv
// ----------------------------------------------------------------------------
// wireless_rx_voltage_fault_monitor_top_test
// Self-checking bench for the receiver voltage fault monitor. A clocked driver
// offers monitor ticks from a queue and predicts each accepted transaction. A
// clocked monitor compares each result with the oldest prediction. Directed
// corner ticks come first, then random phases under reprogrammed thresholds,
// with random idling, one long result stall and drain pauses between phases.
// ----------------------------------------------------------------------------
module wireless_rx_voltage_fault_monitor_top_test;
  import wrvfm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic     tick_valid   = 1'b0;
  in_item_t tick_data    = '0;
  logic     result_ready = 1'b0;

  wrvfm_in_if  tick_ch();
  wrvfm_out_if result_ch();

  assign tick_ch.valid = tick_valid;
  assign {tick_ch.out_volt_mv, tick_ch.bus_volt_mv, tick_ch.out_target_mv,
          tick_ch.avg_current_ma, tick_ch.main_rect_mv, tick_ch.main_out_mv,
          tick_ch.past_handshake, tick_ch.boost_done, tick_ch.vfc_target_mv,
          tick_ch.sleep_enabled, tick_ch.channel_on} = tick_data;
  assign result_ch.ready = result_ready;

  wireless_rx_voltage_fault_monitor_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (tick_ch),
    .out_ch  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // predictor state
  cfg_t                   limits;
  logic [COUNT_WIDTH-1:0] low_vout_run;
  logic [COUNT_WIDTH-1:0] diff_run;

  in_item_t    pending_ticks[$];
  out_item_t   tick_results[$];
  in_item_t    offered;
  out_item_t   want;
  int unsigned ticks_queued   = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned hold_left      = 0;
  logic        no_idle        = 1'b0;

  function automatic int unsigned clamp_ticks(input logic [7:0] ticks);
    return (ticks > CNT_MAX) ? int'(CNT_MAX) : int'(ticks);
  endfunction

  function automatic out_item_t predict_tick(input in_item_t t);
    out_item_t   r;
    int unsigned vmax;
    int unsigned thr;
    int unsigned lim;
    int          excess;
    r = '0;
    if (t.out_volt_mv == 0 || !t.boost_done || !t.past_handshake) begin
      r.volt_status = STATUS_IGNORE;
    end else begin
      vmax = (t.out_volt_mv >= t.bus_volt_mv) ? t.out_volt_mv : t.bus_volt_mv;
      thr  = (int'(t.out_target_mv) * int'(limits.vout_ratio_pct)) / 100;
      if (vmax >= thr) begin
        r.volt_status = STATUS_NORMAL;
      end else if (t.avg_current_ma >= limits.ignore_current_ma) begin
        r.volt_status = STATUS_IGNORE;
      end else begin
        r.volt_status = STATUS_ABNORMAL;
      end
    end

    if (r.volt_status == STATUS_NORMAL) begin
      low_vout_run = '0;
    end else if (r.volt_status == STATUS_ABNORMAL) begin
      lim = clamp_ticks(limits.vout_fault_ticks);
      if (int'(low_vout_run) + 1 < lim) begin
        low_vout_run = low_vout_run + 1'b1;
      end else begin
        low_vout_run = COUNT_WIDTH'(lim);
        if (!t.sleep_enabled && t.vfc_target_mv >= limits.high_vfc_mv) begin
          r.limit_power = 1'b1;
        end else if (t.channel_on) begin
          r.send_ept = 1'b1;
        end
      end
    end

    excess = int'(t.main_rect_mv) - int'(t.main_out_mv);
    if (excess < int'(limits.diff_limit_mv)) begin
      diff_run = '0;
    end else begin
      lim = clamp_ticks(limits.diff_fault_ticks);
      if (int'(diff_run) + 1 < lim) begin
        diff_run = diff_run + 1'b1;
      end else begin
        diff_run     = '0;
        r.diff_fault = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic in_item_t base_tick();
    in_item_t t;
    t.out_volt_mv    = 16'd5000;
    t.bus_volt_mv    = 16'd4000;
    t.out_target_mv  = 16'd5000;
    t.avg_current_ma = 13'd100;
    t.main_rect_mv   = 16'd5200;
    t.main_out_mv    = 16'd5000;
    t.past_handshake = 1'b1;
    t.boost_done     = 1'b1;
    t.vfc_target_mv  = 16'd9000;
    t.sleep_enabled  = 1'b0;
    t.channel_on     = 1'b1;
    return t;
  endfunction

  // mostly well-formed ticks aimed at the counters, the rest pure noise
  function automatic in_item_t make_tick();
    in_item_t    t;
    int unsigned kind;
    int unsigned thr;
    int unsigned top;
    kind             = $urandom_range(99);
    t.out_volt_mv    = 16'($urandom_range(65535));
    t.bus_volt_mv    = 16'($urandom_range(65535));
    t.out_target_mv  = 16'($urandom_range(65535));
    t.avg_current_ma = 13'($urandom_range(8191));
    t.main_rect_mv   = 16'($urandom_range(65535));
    t.main_out_mv    = 16'($urandom_range(65535));
    t.past_handshake = 1'($urandom_range(1));
    t.boost_done     = 1'($urandom_range(1));
    t.vfc_target_mv  = 16'($urandom_range(65535));
    t.sleep_enabled  = 1'($urandom_range(1));
    t.channel_on     = 1'($urandom_range(1));
    if (kind >= 15) begin
      t.past_handshake = ($urandom_range(19) != 0);
      t.boost_done     = ($urandom_range(19) != 0);
      t.sleep_enabled  = ($urandom_range(3) == 0);
      t.channel_on     = ($urandom_range(3) != 0);
      thr = (int'(t.out_target_mv) * int'(limits.vout_ratio_pct)) / 100;
      if (kind < 75 && thr >= 2) begin
        top = (thr - 1 > 65535) ? 65535 : thr - 1;
        t.out_volt_mv = 16'($urandom_range(top, 1));
        t.bus_volt_mv = 16'($urandom_range(top, 0));
        if (limits.ignore_current_ma != 0 && $urandom_range(4) != 0) begin
          t.avg_current_ma = 13'($urandom_range(int'(limits.ignore_current_ma) - 1, 0));
        end
      end else if (thr <= 65535) begin
        t.out_volt_mv = 16'($urandom_range(65535, (thr == 0) ? 1 : thr));
      end
      if ($urandom_range(9) < 6) begin
        top = int'(t.main_out_mv) + int'(limits.diff_limit_mv) + $urandom_range(40);
        if (top <= 65535) begin
          t.main_rect_mv = 16'(top);
        end
      end
    end
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && tick_ch.ready) begin
        tick_results.push_back(predict_tick(offered));
      end
      if (!tick_valid || tick_ch.ready) begin
        if (pending_ticks.size() != 0 && (no_idle || $urandom_range(99) >= 9)) begin
          offered    = pending_ticks.pop_front();
          tick_data  <= offered;
          tick_valid <= 1'b1;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ready) begin
        results_seen++;
        if (tick_results.size() == 0) begin
          $error("result transaction with no tick pending");
          mismatches++;
        end else begin
          want = tick_results.pop_front();
          if (result_ch.volt_status !== want.volt_status) begin
            $error("volt_status: expected %0d, actual %0d",
                   want.volt_status, result_ch.volt_status);
            mismatches++;
          end
          if (result_ch.limit_power !== want.limit_power) begin
            $error("limit_power: expected %0d, actual %0d",
                   want.limit_power, result_ch.limit_power);
            mismatches++;
          end
          if (result_ch.send_ept !== want.send_ept) begin
            $error("send_ept: expected %0d, actual %0d", want.send_ept, result_ch.send_ept);
            mismatches++;
          end
          if (result_ch.diff_fault !== want.diff_fault) begin
            $error("diff_fault: expected %0d, actual %0d",
                   want.diff_fault, result_ch.diff_fault);
            mismatches++;
          end
        end
        if (results_seen == 500) begin
          hold_left = 150;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= no_idle || $urandom_range(99) >= 9;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VOUT_RATIO:     limits.vout_ratio_pct    = value[6:0];
      REG_IGNORE_CURRENT: limits.ignore_current_ma = value[12:0];
      REG_VOUT_TICKS:     limits.vout_fault_ticks  = value[7:0];
      REG_DIFF_TICKS:     limits.diff_fault_ticks  = value[7:0];
      REG_DIFF_LIMIT:     limits.diff_limit_mv     = value[15:0];
      REG_HIGH_VFC:       limits.high_vfc_mv       = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(input int unsigned ratio, input int unsigned ign,
                                input int unsigned vticks, input int unsigned dticks,
                                input int unsigned dlimit, input int unsigned hvfc);
    write_reg(REG_VOUT_RATIO, ratio);
    write_reg(REG_IGNORE_CURRENT, ign);
    write_reg(REG_VOUT_TICKS, vticks);
    write_reg(REG_DIFF_TICKS, dticks);
    write_reg(REG_DIFF_LIMIT, dlimit);
    write_reg(REG_HIGH_VFC, hvfc);
  endtask

  task automatic queue_tick(input in_item_t t);
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen < ticks_queued);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned pick_ticks();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(255);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  initial begin
    in_item_t    t;
    int unsigned ratio;
    int unsigned ign;
    int unsigned dlimit;
    int unsigned hvfc;

    limits.vout_ratio_pct    = RST_VOUT_RATIO;
    limits.ignore_current_ma = RST_IGNORE_CURRENT;
    limits.vout_fault_ticks  = RST_VOUT_TICKS;
    limits.diff_fault_ticks  = RST_DIFF_TICKS;
    limits.diff_limit_mv     = RST_DIFF_LIMIT;
    limits.high_vfc_mv       = RST_HIGH_VFC;
    low_vout_run = '0;
    diff_run     = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed corners under reset thresholds (threshold 4050 for target 5000)
    t = '0;
    queue_tick(t);
    t = '1;
    queue_tick(t);
    t = base_tick();
    queue_tick(t);
    t.boost_done = 1'b0;
    queue_tick(t);
    t = base_tick();
    t.past_handshake = 1'b0;
    queue_tick(t);
    t = base_tick();
    t.out_volt_mv = 16'd4050;
    t.bus_volt_mv = 16'd0;
    queue_tick(t);
    t.out_volt_mv    = 16'd4049;
    t.bus_volt_mv    = 16'd4049;
    t.avg_current_ma = 13'd500;
    queue_tick(t);
    t.avg_current_ma = 13'd499;
    queue_tick(t);
    t.out_volt_mv = 16'd1;
    t.bus_volt_mv = 16'd4050;
    queue_tick(t);
    t = base_tick();
    t.main_rect_mv = 16'd0;
    t.main_out_mv  = 16'd65535;
    queue_tick(t);
    t.main_rect_mv = 16'd7500;
    t.main_out_mv  = 16'd5000;
    queue_tick(t);
    t = base_tick();
    t.out_volt_mv    = 16'd100;
    t.bus_volt_mv    = 16'd200;
    t.avg_current_ma = 13'd0;
    t.vfc_target_mv  = 16'd12000;
    repeat (10) queue_tick(t);
    t.sleep_enabled = 1'b1;
    queue_tick(t);
    t.channel_on = 1'b0;
    queue_tick(t);
    t.sleep_enabled = 1'b0;
    t.channel_on    = 1'b1;
    t.vfc_target_mv = 16'd11999;
    queue_tick(t);
    wait_drained();

    // zero limits, ratio above 100, top thresholds
    program_limits(127, 8191, 0, 0, 0, 65535);
    t = base_tick();
    t.out_volt_mv    = 16'd100;
    t.out_target_mv  = 16'd65535;
    t.avg_current_ma = 13'd8190;
    t.vfc_target_mv  = 16'd65535;
    t.main_rect_mv   = 16'd3000;
    t.main_out_mv    = 16'd3000;
    queue_tick(t);
    queue_tick(t);
    t.sleep_enabled = 1'b1;
    queue_tick(t);
    wait_drained();

    // limits lowered below the running counts
    program_limits(81, 500, 20, 20, 100, 12000);
    t = base_tick();
    t.out_volt_mv    = 16'd100;
    t.bus_volt_mv    = 16'd100;
    t.avg_current_ma = 13'd0;
    t.main_rect_mv   = 16'd6000;
    repeat (6) queue_tick(t);
    wait_drained();
    write_reg(REG_VOUT_TICKS, 2);
    write_reg(REG_DIFF_TICKS, 3);
    repeat (2) queue_tick(t);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0:       ratio = 0;
        1:       ratio = 100;
        2:       ratio = 127;
        default: ratio = $urandom_range(127);
      endcase
      case ($urandom_range(3))
        0:       ign = 0;
        1:       ign = 8191;
        default: ign = $urandom_range(8191);
      endcase
      case ($urandom_range(5))
        0:       dlimit = 0;
        1:       dlimit = 65535;
        2:       dlimit = $urandom_range(65535);
        default: dlimit = $urandom_range(4000);
      endcase
      case ($urandom_range(3))
        0:       hvfc = 0;
        1:       hvfc = 65535;
        default: hvfc = $urandom_range(65535);
      endcase
      program_limits(ratio, ign, pick_ticks(), pick_ticks(), dlimit, hvfc);
      no_idle = (phase == 5);
      repeat (150) queue_tick(make_tick());
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (10) @(posedge clk);
    if (mismatches == 0 && tick_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
